// ----- hw/rtl/plsh_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the p-stable LSH hash engine.
// No dependencies; plsh_if, plsh_ctrl, plsh_dpath and the top level import this package.
package plsh_pkg;

   localparam int KIND_W     = 2;
   localparam int HIDX_W     = 4;
   localparam int CIDX_W     = 10;
   localparam int VALUE_W    = 32;
   localparam int WEIGHT_W   = 16;
   localparam int BIAS_W     = 32;
   localparam int ACC_W      = 40;
   localparam int BW_W       = 16;
   localparam int NH_W       = 5;
   localparam int ND_W       = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int HASH_SLOTS = 16;
   localparam int COORD_W    = 8;
   localparam int PROD_W     = 25;
   localparam int FRAC_W     = 12;
   localparam int QUO_W      = 28;
   localparam int STEP_W     = 5;

   localparam logic [KIND_W-1:0] KIND_WEIGHT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BIAS   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_COORD  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BUCKET_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HASHES_IN_USE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIMS_IN_USE   = 2'd2;

   localparam logic [BW_W-1:0] BW_RESET = 16'd4000;
   localparam logic [NH_W-1:0] NH_RESET = 5'd15;
   localparam logic [ND_W-1:0] ND_RESET = 11'd784;

   localparam logic [STEP_W-1:0] DIV_LAST_STEP = 5'd27;

   typedef struct packed {
      logic              capture;
      logic              write_weight;
      logic              write_bias;
      logic              mac_start;
      logic              mac_issue;
      logic              div_load;
      logic              div_step;
      logic              out_load;
      logic              acc_clear;
      logic [HIDX_W-1:0] hash_idx;
   } plsh_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              weight_ok;
      logic              bias_ok;
      logic              coord_ok;
      logic              coord_last;
      logic              hash_last;
      logic              out_free;
   } plsh_status_type;

endpackage

// ----- hw/rtl/plsh_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces: input items, result items and register writes.
// Depends on plsh_pkg for field widths.
interface plsh_req_if import plsh_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         kind;
   logic [HIDX_W-1:0]         hash_index;
   logic [CIDX_W-1:0]         coord_index;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, kind, hash_index, coord_index, value, input ready);
   modport sink (input valid, kind, hash_index, coord_index, value, output ready);
endinterface

interface plsh_rsp_if import plsh_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [HIDX_W-1:0]         hash_number;
   logic signed [VALUE_W-1:0] hash_value;
   logic                      last;

   modport source (output valid, hash_number, hash_value, last, input ready);
   modport sink (input valid, hash_number, hash_value, last, output ready);
endinterface

interface plsh_csr_if import plsh_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/plsh_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module plsh_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/plsh_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the LSH hash engine: decodes items, steps the MAC over the hashes,
// runs the divider and output per hash. Depends on plsh_pkg.
module plsh_ctrl import plsh_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  plsh_status_type status,
   output plsh_cmd_type    cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_MAC    = 4'd2;
   localparam logic [3:0] S_DRAIN1 = 4'd3;
   localparam logic [3:0] S_DRAIN2 = 4'd4;
   localparam logic [3:0] S_HREAD  = 4'd5;
   localparam logic [3:0] S_HLOAD  = 4'd6;
   localparam logic [3:0] S_HDIV   = 4'd7;
   localparam logic [3:0] S_HOUT   = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [HIDX_W-1:0] h_ff, h_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in     = state_ff;
      h_in         = h_ff;
      step_in      = step_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.hash_idx = h_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_IDLE;
            case (status.kind)
               KIND_WEIGHT: cmd.write_weight = status.weight_ok;
               KIND_BIAS:   cmd.write_bias   = status.bias_ok;
               KIND_COORD: begin
                  if (status.coord_ok) begin
                     cmd.mac_start = 1'b1;
                     h_in          = '0;
                     state_in      = S_MAC;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_MAC: begin
            cmd.mac_issue = 1'b1;
            if (status.hash_last) begin
               state_in = S_DRAIN1;
            end else begin
               h_in = h_ff + HIDX_W'(1);
            end
         end
         S_DRAIN1: state_in = S_DRAIN2;
         S_DRAIN2: begin
            if (status.coord_last) begin
               h_in     = '0;
               state_in = S_HREAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_HREAD: state_in = S_HLOAD;
         S_HLOAD: begin
            cmd.div_load = 1'b1;
            step_in      = '0;
            state_in     = S_HDIV;
         end
         S_HDIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == DIV_LAST_STEP) begin
               state_in = S_HOUT;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_HOUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (status.hash_last) begin
                  cmd.acc_clear = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  h_in     = h_ff + HIDX_W'(1);
                  state_in = S_HREAD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         h_ff     <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         h_ff     <= h_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ----- hw/rtl/plsh_dpath.sv -----
`timescale 1ns / 1ps
// Datapath of the LSH hash engine: registers, weight and bias memories, MAC pipeline,
// accumulators, bit-serial floor divider and result register. Depends on plsh_pkg, plsh_ram.
module plsh_dpath import plsh_pkg::*; #(
   parameter int DIM      = 784,
   parameter int NUM_HASH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  plsh_cmd_type              cmd,
   output plsh_status_type           status,
   input  logic [KIND_W-1:0]         req_kind,
   input  logic [HIDX_W-1:0]         req_hash_index,
   input  logic [CIDX_W-1:0]         req_coord_index,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      csr_write,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [HIDX_W-1:0]         rsp_hash_number,
   output logic signed [VALUE_W-1:0] rsp_hash_value,
   output logic                      rsp_last
);

   localparam int HASH_CAP = (NUM_HASH < HASH_SLOTS) ? NUM_HASH : HASH_SLOTS;
   localparam int W_DEPTH  = HASH_CAP * DIM;
   localparam int W_ADDR_W = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;

   logic [BW_W-1:0] bw_ff;
   logic [NH_W-1:0] nh_cfg_ff;
   logic [ND_W-1:0] nd_cfg_ff;
   logic [NH_W-1:0] nh;
   logic [ND_W-1:0] nd;
   logic [BW_W-1:0] divisor;

   logic [KIND_W-1:0]         kind_ff;
   logic [HIDX_W-1:0]         hidx_ff;
   logic [CIDX_W-1:0]         cidx_ff;
   logic signed [VALUE_W-1:0] val_ff;

   logic [W_ADDR_W-1:0]       addr_ff;
   logic [W_ADDR_W-1:0]       w_waddr;
   logic [WEIGHT_W-1:0]       w_rdata;
   logic [BIAS_W-1:0]         b_rdata;
   logic [COORD_W-1:0]        coord;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [PROD_W-1:0]  prod_ff;
   logic                      v1_ff, v2_ff;
   logic [HIDX_W-1:0]         h1_ff, h2_ff;
   logic [HASH_SLOTS-1:0][ACC_W-1:0] acc_ff;

   logic signed [ACC_W:0]     num;
   logic                      num_neg;
   logic [BW_W:0]             trial;
   logic [BW_W:0]             diff;
   logic                      fits;
   logic [QUO_W-1:0]          quo_ff;
   logic [BW_W-1:0]           rem_ff;
   logic                      neg_ff;

   logic                      rsp_valid_ff;
   logic [HIDX_W-1:0]         rsp_hash_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic                      rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff     <= BW_RESET;
         nh_cfg_ff <= NH_RESET;
         nd_cfg_ff <= ND_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_BUCKET_WIDTH:  bw_ff     <= csr_data;
            CSR_HASHES_IN_USE: nh_cfg_ff <= csr_data[NH_W-1:0];
            CSR_DIMS_IN_USE:   nd_cfg_ff <= csr_data[ND_W-1:0];
            default: ;
         endcase
      end
   end

   assign nh = (nh_cfg_ff == '0) ? NH_W'(1) :
               (nh_cfg_ff > NH_W'(HASH_CAP)) ? NH_W'(HASH_CAP) : nh_cfg_ff;
   assign nd = (nd_cfg_ff == '0) ? ND_W'(1) :
               (nd_cfg_ff > ND_W'(DIM)) ? ND_W'(DIM) : nd_cfg_ff;
   assign divisor = (bw_ff == '0) ? BW_W'(1) : bw_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         hidx_ff <= req_hash_index;
         cidx_ff <= req_coord_index;
         val_ff  <= req_value;
      end
   end

   assign status.kind       = kind_ff;
   assign status.bias_ok    = {1'b0, hidx_ff} < NH_W'(HASH_CAP);
   assign status.weight_ok  = status.bias_ok && ({1'b0, cidx_ff} < ND_W'(DIM));
   assign status.coord_ok   = {1'b0, cidx_ff} < nd;
   assign status.coord_last = {1'b0, cidx_ff} == (nd - ND_W'(1));
   assign status.hash_last  = {1'b0, cmd.hash_idx} == (nh - NH_W'(1));
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign w_waddr = W_ADDR_W'(int'(hidx_ff) * DIM + int'(cidx_ff));

   always_ff @(posedge clock) begin
      if (cmd.mac_start) begin
         addr_ff <= W_ADDR_W'(cidx_ff);
      end else if (cmd.mac_issue) begin
         addr_ff <= addr_ff + W_ADDR_W'(DIM);
      end
   end

   plsh_ram #(.WIDTH(WEIGHT_W), .DEPTH(W_DEPTH)) u_weight_ram (
      .clock (clock),
      .we    (cmd.write_weight),
      .waddr (w_waddr),
      .wdata (val_ff[WEIGHT_W-1:0]),
      .raddr (addr_ff),
      .rdata (w_rdata)
   );

   plsh_ram #(.WIDTH(BIAS_W), .DEPTH(HASH_SLOTS)) u_bias_ram (
      .clock (clock),
      .we    (cmd.write_bias),
      .waddr (hidx_ff),
      .wdata (val_ff),
      .raddr (cmd.hash_idx),
      .rdata (b_rdata)
   );

   assign coord = val_ff[VALUE_W-1] ? '0 :
                  (|val_ff[VALUE_W-2:COORD_W]) ? '1 : val_ff[COORD_W-1:0];
   assign prod_in = $signed({1'b0, coord}) * $signed(w_rdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.mac_issue;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      h1_ff <= cmd.hash_idx;
      h2_ff <= h1_ff;
      if (v1_ff) begin
         prod_ff <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.acc_clear) begin
         acc_ff <= '0;
      end else if (v2_ff) begin
         acc_ff[h2_ff] <= acc_ff[h2_ff] + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
   end

   assign num = $signed({acc_ff[cmd.hash_idx][ACC_W-1], acc_ff[cmd.hash_idx]}) +
                $signed({{(ACC_W+1-BIAS_W){b_rdata[BIAS_W-1]}}, b_rdata});
   assign num_neg = num[ACC_W];

   assign trial = {rem_ff, quo_ff[QUO_W-1]};
   assign fits  = trial >= {1'b0, divisor};
   assign diff  = trial - {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         quo_ff <= num[ACC_W-1:FRAC_W] ^ {QUO_W{num_neg}};
         rem_ff <= '0;
         neg_ff <= num_neg;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[QUO_W-2:0], fits};
         rem_ff <= fits ? diff[BW_W-1:0] : trial[BW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_hash_ff  <= cmd.hash_idx;
         rsp_value_ff <= {{(VALUE_W-QUO_W){neg_ff}}, quo_ff ^ {QUO_W{neg_ff}}};
         rsp_last_ff  <= status.hash_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hash_number = rsp_hash_ff;
   assign rsp_hash_value  = rsp_value_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTHESIS
   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result loaded over a pending item");

   a_out_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_mac_drained: assert property (@(posedge clock) disable iff (reset)
      (v1_ff || v2_ff) |-> !cmd.div_load && !cmd.capture)
      else $error("MAC pipeline not drained");

   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.acc_clear |=> acc_ff == '0)
      else $error("accumulators not cleared after point");
`endif

endmodule

// ----- hw/rtl/pstable_lsh_hash_engine.sv -----
`timescale 1ns / 1ps
// Top level of the p-stable Euclidean LSH hash engine.
// Depends on plsh_pkg, plsh_if, plsh_ctrl, plsh_dpath.
//
// Weights (Q4.12) and scaled biases are loaded with kind 0 and kind 1 items; points then
// stream in one coordinate per item (kind 2). An item is taken only once the previous one
// is done. A coordinate item makes one read of the weight memory and one shared 9x16
// multiply-accumulate per hash. The final coordinate of a point then runs the 28-step
// bit-serial floor divider per hash and emits one item per hash in order, last marking
// the final one; a stalled result side holds the next hash.
// The weight and bias memories are not cleared by reset; the accumulators are, and they
// are cleared again after each point. Register writes are taken at any time and must
// only be issued while the block is idle.
module pstable_lsh_hash_engine import plsh_pkg::*; #(
   parameter int DIM      = 784,
   parameter int NUM_HASH = 16
) (
   input logic        clock,
   input logic        reset,
   plsh_req_if.sink   req_ch,
   plsh_rsp_if.source rsp_ch,
   plsh_csr_if.sink   csr_ch
);

   plsh_cmd_type    cmd;
   plsh_status_type status;

   assign csr_ch.ready = 1'b1;

   plsh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   plsh_dpath #(.DIM(DIM), .NUM_HASH(NUM_HASH)) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_kind        (req_ch.kind),
      .req_hash_index  (req_ch.hash_index),
      .req_coord_index (req_ch.coord_index),
      .req_value       (req_ch.value),
      .csr_write       (csr_ch.valid),
      .csr_index       (csr_ch.index),
      .csr_data        (csr_ch.data),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_hash_number (rsp_ch.hash_number),
      .rsp_hash_value  (rsp_ch.hash_value),
      .rsp_last        (rsp_ch.last)
   );

endmodule
